/* rtl/nps_pkg.sv */
// nps_pkg: item types, field widths and status codes for the nearest point search block
// no dependencies; used by every module of the block

package nps_pkg;

  localparam int COORD_W  = 16;
  localparam int INDEX_W  = 10;
  localparam int DIST_W   = 34;
  localparam int STATUS_W = 2;
  localparam int SQ_W     = 2 * COORD_W;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
  } point_t;

  typedef struct packed {
    logic   op;
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  nearest_index;
    logic [DIST_W-1:0]   nearest_dist;
    logic [STATUS_W-1:0] status;
  } out_item_t;

endpackage

/* rtl/nps_dist_pipe.sv */
// nps_dist_pipe: three-stage squared distance pipeline (abs diff, square, sum)
// depends on nps_pkg; a tag travels alongside each valid sample

module nps_dist_pipe import nps_pkg::*; #(
  parameter int TAG_W = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_v,
  input  logic [TAG_W-1:0]  in_tag,
  input  point_t            q,
  input  point_t            p,
  output logic              out_v,
  output logic [TAG_W-1:0]  out_tag,
  output logic [DIST_W-1:0] out_dist,
  output logic              busy
);

  logic              v1_r, v2_r, v3_r;
  logic [TAG_W-1:0]  tag1_r, tag2_r, tag3_r;
  logic [COORD_W-1:0] ad_r [3];
  logic [SQ_W-1:0]    sq_r [3];
  logic [DIST_W-1:0]  dist_r;

  coord_t             qa [3];
  coord_t             pa [3];
  logic [COORD_W-1:0] ad_nxt [3];
  logic [SQ_W-1:0]    sq_nxt [3];
  logic [DIST_W-1:0]  dist_nxt;

  function automatic logic [COORD_W-1:0] abs_diff(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? -d : d;
    // largest magnitude is 2**COORD_W - 1, so the top bit is always clear
    return m[COORD_W-1:0];
  endfunction

  always_comb begin
    qa[0] = q.pos_x;
    qa[1] = q.pos_y;
    qa[2] = q.pos_z;
    pa[0] = p.pos_x;
    pa[1] = p.pos_y;
    pa[2] = p.pos_z;
    for (int k = 0; k < 3; k++) begin
      ad_nxt[k] = abs_diff(qa[k], pa[k]);
      sq_nxt[k] = ad_r[k] * ad_r[k];
    end
    dist_nxt = DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    tag1_r <= in_tag;
    tag2_r <= tag1_r;
    tag3_r <= tag2_r;
    for (int k = 0; k < 3; k++) begin
      ad_r[k] <= ad_nxt[k];
      sq_r[k] <= sq_nxt[k];
    end
    dist_r <= dist_nxt;
  end

  assign out_v    = v3_r;
  assign out_tag  = tag3_r;
  assign out_dist = dist_r;
  assign busy     = v1_r | v2_r | v3_r;

endmodule

/* rtl/nearest_point_search.sv */
// nearest_point_search: point store in one synchronous ram, brute-force nearest query
// depends on nps_pkg and nps_dist_pipe
//
//  channel | ports                       | direction | item
//  in      | in_valid in_ready in_item   | input     | op, pos_x, pos_y, pos_z
//  out     | out_valid out_ready out_item| output    | nearest_index, nearest_dist, status
//
// one item at a time; an insert or an empty query goes through the result register
// into the output register once that is free, a query makes one ram read per stored point
// followed by the ram read register and the distance/compare pipeline
// rst_n clears the point count and control; ram contents are not cleared
// a new item is accepted while a finished result waits on out_ready; a stalled output
// holds the next result back until the output register frees up

module nearest_point_search import nps_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t     state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  point_t     q_r;
  out_item_t  res_r, res_nxt;
  out_item_t  out_r;
  logic       out_valid_r, out_valid_nxt;

  point_t     mem [MAX_POINTS];
  point_t     rdata_r;
  logic       rd_v_r;
  logic [IDX_W-1:0] rd_tag_r;

  logic       in_fire, out_free, issue, mem_we, pipe_busy;
  logic       sum_v;
  logic [IDX_W-1:0]  sum_tag;
  logic [DIST_W-1:0] sum_dist;
  logic [IDX_W-1:0]  best_idx_r;
  logic [DIST_W-1:0] best_dist_r;
  point_t     wdata;

  function automatic logic [INDEX_W-1:0] to_index(input logic [IDX_W-1:0] v);
    logic [IDX_W+INDEX_W-1:0] w;
    w = {{INDEX_W{1'b0}}, v};
    return w[INDEX_W-1:0];
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign issue     = (state_r == S_SCAN) && (iss_r < count_r);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign wdata.pos_x = in_item.pos_x;
  assign wdata.pos_y = in_item.pos_y;
  assign wdata.pos_z = in_item.pos_z;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    iss_nxt   = iss_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt.nearest_index = '0;
          res_nxt.nearest_dist  = '0;
          res_nxt.status        = ST_OK;
          state_nxt             = S_FINISH;
          if (in_item.op == OP_INSERT) begin
            if (count_r < CNT_W'(MAX_POINTS)) begin
              mem_we                = 1'b1;
              count_nxt             = count_r + 1'b1;
              res_nxt.nearest_index = to_index(count_r[IDX_W-1:0]);
            end else begin
              res_nxt.status = ST_FULL;
            end
          end else if (count_r == '0) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            iss_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          iss_nxt = iss_r + 1'b1;
        end
        // all reads issued and the last compare has landed in the best registers
        if (!issue && !rd_v_r && !pipe_busy) begin
          res_nxt.nearest_index = to_index(best_idx_r);
          res_nxt.nearest_dist  = best_dist_r;
          res_nxt.status        = ST_OK;
          state_nxt             = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_FINISH && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      iss_r       <= '0;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      iss_r       <= iss_nxt;
      out_valid_r <= out_valid_nxt;
      rd_v_r      <= issue;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_fire) begin
      q_r <= wdata;
    end
    if (state_r == S_FINISH && out_free) begin
      out_r <= res_r;
    end
    rd_tag_r <= iss_r[IDX_W-1:0];
    // first point seeds the running best, later ones replace it only when strictly closer
    if (sum_v && (sum_tag == '0 || sum_dist < best_dist_r)) begin
      best_idx_r  <= sum_tag;
      best_dist_r <= sum_dist;
    end
  end

  // point store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= wdata;
    end
    if (issue) begin
      rdata_r <= mem[iss_r[IDX_W-1:0]];
    end
  end

  nps_dist_pipe #(
    .TAG_W (IDX_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (rd_v_r),
    .in_tag   (rd_tag_r),
    .q        (q_r),
    .p        (rdata_r),
    .out_v    (sum_v),
    .out_tag  (sum_tag),
    .out_dist (sum_dist),
    .busy     (pipe_busy)
  );

endmodule

/* rtl/nps_checker.sv */
// nps_checker: port-level checks on the channels of nearest_point_search
// depends on nps_pkg; attached to the top level by the bind below

module nps_checker import nps_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // a result waiting for out_ready is not withdrawn or changed
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item dropped or changed before it was taken");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.status != ST_BAD)
    else $error("result item carries an unused status code");

  // refused inserts and empty queries report zero index and distance
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_FULL || out_item.status == ST_EMPTY)
      |-> out_item.nearest_index == '0 && out_item.nearest_dist == '0)
    else $error("error status with nonzero index or distance");

  // one item at a time: the input closes right after an item is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after an item was accepted");

endmodule

bind nearest_point_search nps_checker u_nps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
